FILE: sv/hsl2rgb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the HSL to RGB converter.
// No dependencies.
package hsl2rgb_pkg;

  localparam int HUE_W        = 16;
  localparam int SAT_W        = 16;
  localparam int LIT_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int FRAC_BITS_DEF = 15;

  // Per-stage load enables handed from the pipeline control to each channel
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } hsl2rgb_en_t;

endpackage

FILE: sv/hsl2rgb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in (HSL) and out (RGB).
// Depends on hsl2rgb_pkg.
interface hsl2rgb_in_if import hsl2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [LIT_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

interface hsl2rgb_out_if import hsl2rgb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: sv/hsl2rgb_chan.sv
`timescale 1ns / 1ps
// One color channel: hue position to ramp weight, weight times chroma,
// scale by 255 and round. Depends on hsl2rgb_pkg.
module hsl2rgb_chan import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  hsl2rgb_en_t           en,
  input  logic [FRAC_BITS+2:0]  pos,     // stage 2, 0..6*ONE
  input  logic [FRAC_BITS:0]    chroma,  // stage 2 register
  input  logic [FRAC_BITS:0]    floor_p, // stage 3 register
  output logic [CHAN_W-1:0]     byte_r
);

  localparam int F  = FRAC_BITS;
  localparam int HW = F + 3;
  localparam int VW = F + 1;
  localparam int PW = 2 * F + 2;
  localparam int YW = 2 * F + 9;

  localparam logic [HW-1:0] ONE_P   = HW'(1) << F;
  localparam logic [HW-1:0] THREE_P = HW'(3) << F;
  localparam logic [HW-1:0] FOUR_P  = HW'(4) << F;
  localparam logic [YW-1:0] HALF_Y  = YW'(1) << (2 * F - 1);

  logic [VW-1:0] d_r, d_nxt;
  logic [HW-1:0] down;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [PW-1:0] v_sum;
  logic [PW-2:0] v_r, v_nxt;
  logic [YW-1:0] y;
  logic [CHAN_W-1:0] byte_nxt;

  // weight d in 0..ONE: rising ramp, plateau, falling ramp, floor
  always_comb begin
    down = FOUR_P - pos;
    priority if (pos < ONE_P) begin
      d_nxt = pos[F:0];
    end else if (pos < THREE_P) begin
      d_nxt = ONE_P[F:0];
    end else if (pos < FOUR_P) begin
      d_nxt = down[F:0];
    end else begin
      d_nxt = '0;
    end
  end

  assign prod_nxt = PW'(chroma) * PW'(d_r);

  // v = p*ONE + 2*c*d, never above ONE^2
  assign v_sum = (PW'(floor_p) << F) + (prod_r << 1);
  assign v_nxt = v_sum[PW-2:0];

  // 255*v + half, top byte; cannot exceed 255
  assign y        = (YW'(v_r) << 8) - YW'(v_r) + HALF_Y;
  assign byte_nxt = y[2*F+7:2*F];

  always_ff @(posedge clk) begin
    if (en.s2) d_r    <= d_nxt;
    if (en.s3) prod_r <= prod_nxt;
    if (en.s4) v_r    <= v_nxt;
    if (en.s5) byte_r <= byte_nxt;
  end

endmodule

FILE: sv/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// HSL to RGB pixel converter, five-stage pipeline, top level.
// Depends on hsl2rgb_pkg, hsl2rgb_if.sv and hsl2rgb_chan.
//
//   channel  dir  handshake      payload
//   in_pix   in   valid/ready    hue, saturation, lightness (16b each)
//   out_pix  out  valid/ready    red, green, blue (8b each)
//
// One pixel per clock unless out_pix.ready holds the pipeline back; out_pix.valid
// rises once the accepted pixel reaches the stage 5 register.
// Stages: clamp/min and 6*hue, chroma multiply and channel positions,
// weight multiply, sum, scale by 255 and round.
// rst_n (synchronous) clears the stage valid bits only.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and in_pix.ready stays high unless all five stages are full.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hsl2rgb_in_if.sink    in_pix,
  hsl2rgb_out_if.source out_pix
);

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 1;
  localparam int HW = F + 3;
  localparam int CW = (F >= 16) ? F + 1 : 17;
  localparam int MW = 2 * F + 2;

  localparam logic [CW-1:0] ONE_C   = CW'(1) << F;
  localparam logic [VW-1:0] ONE_V   = VW'(1) << F;
  localparam logic [VW-1:0] HALF_V  = VW'(1) << (F - 1);
  localparam logic [MW-1:0] HALF_M  = MW'(1) << (F - 1);
  localparam logic [HW:0]   TWO_R   = (HW + 1)'(2) << F;
  localparam logic [HW:0]   SIX_R   = (HW + 1)'(6) << F;
  localparam logic [HW-1:0] TWO_P   = HW'(2) << F;
  localparam logic [HW-1:0] FOUR_P  = HW'(4) << F;

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1;
  hsl2rgb_en_t en;

  assign en.s5 = !v5_r || out_pix.ready;
  assign en.s4 = !v4_r || en.s5;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en1   = !v1_r || en.s2;

  assign in_pix.ready  = en1;
  assign out_pix.valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1)   v1_r <= in_pix.valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
      if (en.s5) v5_r <= v4_r;
    end
  end

  // stage 1: wrap hue, clamp S and L, m = min(L, 1-L), 6*hue
  logic [CW-1:0] hue_x, sat_x, lit_x;
  logic [F-1:0]  h;
  logic [VW-1:0] s_c, l_c, l_inv;
  logic [VW-1:0] s1_s_r, s1_l_r, s1_m_r;
  logic [HW-1:0] s1_h6_r, h6_nxt;

  assign hue_x = CW'(in_pix.hue);
  assign sat_x = CW'(in_pix.saturation);
  assign lit_x = CW'(in_pix.lightness);
  assign h     = hue_x[F-1:0];
  assign s_c   = (sat_x > ONE_C) ? ONE_V : sat_x[F:0];
  assign l_c   = (lit_x > ONE_C) ? ONE_V : lit_x[F:0];
  assign l_inv = ONE_V - l_c;
  assign h6_nxt = (HW'(h) << 2) + (HW'(h) << 1);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_s_r  <= s_c;
      s1_l_r  <= l_c;
      s1_m_r  <= (l_c < l_inv) ? l_c : l_inv;
      s1_h6_r <= h6_nxt;
    end
  end

  // stage 2: chroma c = round(S*m), channel positions (wrapped into 0..6)
  logic [MW-1:0] sm_sum;
  logic [VW-1:0] s2_c_r, s2_l_r;
  logic [HW:0]   red_t, red_w;
  logic [HW-1:0] pos_red, pos_green, pos_blue;

  assign sm_sum = MW'(s1_s_r) * MW'(s1_m_r) + HALF_M;

  assign red_t     = {1'b0, s1_h6_r} + TWO_R;
  assign red_w     = (red_t > SIX_R) ? red_t - SIX_R : red_t;
  assign pos_red   = red_w[HW-1:0];
  assign pos_green = s1_h6_r;
  assign pos_blue  = (s1_h6_r < TWO_P) ? s1_h6_r + FOUR_P : s1_h6_r - TWO_P;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_c_r <= sm_sum[F+F:F];
      s2_l_r <= s1_l_r;
    end
  end

  // stage 3: floor level p = L - c
  logic [VW-1:0] s3_p_r;

  always_ff @(posedge clk) begin
    if (en.s3) s3_p_r <= s2_l_r - s2_c_r;
  end

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk     (clk),
    .en      (en),
    .pos     (pos_red),
    .chroma  (s2_c_r),
    .floor_p (s3_p_r),
    .byte_r  (out_pix.red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk     (clk),
    .en      (en),
    .pos     (pos_green),
    .chroma  (s2_c_r),
    .floor_p (s3_p_r),
    .byte_r  (out_pix.green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk     (clk),
    .en      (en),
    .pos     (pos_blue),
    .chroma  (s2_c_r),
    .floor_p (s3_p_r),
    .byte_r  (out_pix.blue)
  );

  // input stalls only when every stage is full
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (v1_r && v2_r && v3_r && v4_r && v5_r))
    else $error("input stalled with a bubble in the pipeline");

  // chroma never exceeds one half
  a_chroma_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (s2_c_r <= HALF_V))
    else $error("chroma above one half");

  // an input transfer always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> v1_r)
    else $error("accepted pixel lost at stage 1");

endmodule
